@@ src/tlg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and codes of the training loss and gradient engine.
// No dependencies; every other file refers to it by scoped names.
package tlg_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int DEF_MAX_ELEMENTS = 65536;
  localparam int DEF_NUM_CLASSES  = 1024;
  localparam int CNT_CAP_LIMIT    = 131071;

  localparam int CNT_W      = 17;
  localparam int SUM_W      = 64;
  localparam int TERM_W     = 52;
  localparam int NL_W       = 21;
  localparam int PROB_W     = 16;
  localparam int DIV_NW     = 64;
  localparam int DIV_DW     = 17;
  localparam int IN_TDATA_W = 88;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [1:0] KIND_MSE    = 2'd0;
  localparam logic [1:0] KIND_BCE    = 2'd1;
  localparam logic [1:0] KIND_CCE    = 2'd2;
  localparam logic [1:0] KIND_SPARSE = 2'd3;

  localparam logic REG_LOSS_KIND = 1'b0;
  localparam logic REG_WANT_GRAD = 1'b1;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_CAPTURE   = 4'd1;
  localparam logic [3:0] OP_MSE_GRAD  = 4'd2;
  localparam logic [3:0] OP_MSE_SQ    = 4'd3;
  localparam logic [3:0] OP_LOG_INIT  = 4'd4;
  localparam logic [3:0] OP_LOG_STEP  = 4'd5;
  localparam logic [3:0] OP_LOG_MUL   = 4'd6;
  localparam logic [3:0] OP_LOG_END   = 4'd7;
  localparam logic [3:0] OP_BCE_MUL   = 4'd8;
  localparam logic [3:0] OP_BCE_SUM   = 4'd9;
  localparam logic [3:0] OP_DIV_START = 4'd10;
  localparam logic [3:0] OP_TERM_ADD  = 4'd11;
  localparam logic [3:0] OP_TERM_SUB  = 4'd12;
  localparam logic [3:0] OP_ACC       = 4'd13;
  localparam logic [3:0] OP_OUT       = 4'd14;

  localparam logic [1:0] DSEL_TCQ  = 2'd0;
  localparam logic [1:0] DSEL_TP   = 2'd1;
  localparam logic [1:0] DSEL_ONEP = 2'd2;
  localparam logic [1:0] DSEL_MEAN = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    logic       sel;
    logic [1:0] dsel;
  } tlg_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       grad;
    logic       positive;
    logic       last;
    logic       div_done;
    logic       out_free;
  } tlg_stat_t;

endpackage

@@ src/tlg_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Uses tlg_pkg for default widths.
module tlg_div #(
  parameter int NW = tlg_pkg::DIV_NW,
  parameter int DW = tlg_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic          qbit;

  always_comb begin
    trial   = {rem_r, num_r[NW-1]};
    qbit    = trial >= {1'b0, den_r};
    rem_nxt = qbit ? DW'(trial - {1'b0, den_r}) : DW'(trial);
    num_nxt = {num_r[NW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 1'b1;
      done_r <= cnt_r == CW'(NW - 1);
      busy_r <= cnt_r != CW'(NW - 1);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

@@ src/tlg_dp.sv @@
`timescale 1ns / 1ps
// Datapath: input capture, loss and gradient terms, logarithm, accumulator,
// counts, mean and output register. Uses tlg_pkg and tlg_div.
module tlg_dp #(
  parameter int MAX_ELEMENTS = tlg_pkg::DEF_MAX_ELEMENTS,
  parameter int NUM_CLASSES  = tlg_pkg::DEF_NUM_CLASSES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tlg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  input  logic                            cfg_we,
  input  logic                            cfg_addr,
  input  logic [1:0]                      cfg_wdata,
  input  tlg_pkg::tlg_cmd_t               cmd,
  output tlg_pkg::tlg_stat_t              stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,
  output logic                            out_tuser
);

  localparam int TW = tlg_pkg::TERM_W;
  localparam int CW = tlg_pkg::CNT_W;
  localparam int COUNT_CAP = (MAX_ELEMENTS < tlg_pkg::CNT_CAP_LIMIT) ?
                             MAX_ELEMENTS : tlg_pkg::CNT_CAP_LIMIT;

  logic [1:0]  kind_r;
  logic        grad_r;
  logic [32:0] d_r;
  logic [31:0] truth_r;
  logic [15:0] p_r;
  logic        pos_r, last_r;
  logic [TW-1:0] term_r;
  logic [3:0]  e_r;
  logic [30:0] m_r;
  logic [31:0] frac_r;
  logic [62:0] lprod_r;
  logic [tlg_pkg::NL_W-1:0] nlp_r, nlq_r;
  logic [53:0] mt_r;
  logic [54:0] mq_r;
  logic [63:0] sum_r;
  logic [CW-1:0] ec_r, rc_r;
  logic        clip_r, neg_r;
  logic        out_valid_r, out_sat_r;
  logic [31:0] out_data_r;

  logic [31:0] in_pred, in_truth;
  logic [9:0]  in_cls, in_lbl;
  logic [15:0] p_c, q_c, lx;
  logic        pos_c;
  logic [3:0]  le;
  logic [30:0] m_init;
  logic [61:0] lsq;
  logic [31:0] lt;
  logic [36:0] ldist;
  logic [62:0] lrnd;
  logic [32:0] tc, ra, ramag, dmag;
  logic [15:0] rb;
  logic [63:0] sq, div_num, mmag;
  logic [64:0] sq_rnd, acc_s;
  logic [16:0] div_den, divv;
  logic [55:0] bce_v, bce_mag, bce_rnd;
  logic [53:0] mt_c;
  logic [54:0] mq_c;
  logic        div_start, div_done, neg_c;
  logic [63:0] quo;
  logic [TW-1:0] qterm;
  logic [31:0] mean_c;
  logic        mean_sat;

  assign in_pred  = in_tdata[31:0];
  assign in_truth = in_tdata[63:32];
  assign in_cls   = in_tdata[73:64];
  assign in_lbl   = in_tdata[83:74];

  always_comb begin
    if ($signed(in_pred) < 32'sd1) begin
      p_c = 16'd1;
    end else if ($signed(in_pred) > 32'sd65535) begin
      p_c = 16'hFFFF;
    end else begin
      p_c = in_pred[15:0];
    end
    if (kind_r == tlg_pkg::KIND_CCE) begin
      pos_c = in_truth == 32'h0001_0000;
    end else begin
      pos_c = (in_cls == in_lbl) && ({22'd0, in_lbl} < NUM_CLASSES);
    end
  end

  assign q_c = 16'd0 - p_r;
  assign tc  = 33'h1_0000 - {truth_r[31], truth_r};

  always_comb begin
    lx = cmd.sel ? q_c : p_r;
    le = '0;
    for (int i = 0; i < 16; i++) begin
      if (lx[i]) le = 4'(i);
    end
    m_init = 31'(lx) << (5'd30 - {1'b0, le});
    lsq    = 62'(m_r) * 62'(m_r);
    lt     = lsq[61:30];
    ldist  = {5'd16, 32'd0} - {1'b0, e_r, frac_r};
    lrnd   = lprod_r + (63'd1 << 41);
  end

  always_comb begin
    dmag   = d_r[32] ? 33'd0 - d_r : d_r;
    sq     = 64'(dmag[31:0]) * 64'(dmag[31:0]);
    sq_rnd = 65'(sq) + 65'd32768;
    mt_c   = $signed(truth_r) * $signed({1'b0, nlp_r});
    mq_c   = $signed(tc) * $signed({1'b0, nlq_r});
    bce_v  = {{2{mt_r[53]}}, mt_r} + {mq_r[54], mq_r};
    bce_mag = bce_v[55] ? 56'd0 - bce_v : bce_v;
    bce_rnd = (bce_mag + 56'd32768) >> 16;
  end

  always_comb begin
    case (cmd.dsel)
      tlg_pkg::DSEL_TCQ: begin
        ra = tc;
        rb = q_c;
      end
      tlg_pkg::DSEL_TP: begin
        ra = {truth_r[31], truth_r};
        rb = p_r;
      end
      default: begin
        ra = 33'h1_0000;
        rb = p_r;
      end
    endcase
    ramag = ra[32] ? 33'd0 - ra : ra;
    divv  = (kind_r == tlg_pkg::KIND_MSE || kind_r == tlg_pkg::KIND_BCE) ? ec_r : rc_r;
    if (divv == '0) divv = 17'd1;
    mmag  = sum_r[63] ? 64'd0 - sum_r : sum_r;
    if (cmd.dsel == tlg_pkg::DSEL_MEAN) begin
      div_num = mmag + 64'(divv >> 1);
      div_den = divv;
      neg_c   = sum_r[63];
    end else begin
      div_num = 64'({ramag, 16'd0}) + 64'(rb >> 1);
      div_den = 17'(rb);
      neg_c   = ra[32];
    end
  end

  assign div_start = cmd.op == tlg_pkg::OP_DIV_START;

  tlg_div #(
    .NW(tlg_pkg::DIV_NW),
    .DW(tlg_pkg::DIV_DW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo)
  );

  always_comb begin
    qterm = neg_r ? TW'(0) - TW'(quo) : TW'(quo);
    acc_s = {sum_r[63], sum_r} + {{(65 - TW){term_r[TW-1]}}, term_r};
    mean_sat = 1'b0;
    if (!neg_r && quo > 64'h7FFF_FFFF) begin
      mean_c   = 32'h7FFF_FFFF;
      mean_sat = 1'b1;
    end else if (neg_r && quo > 64'h8000_0000) begin
      mean_c   = 32'h8000_0000;
      mean_sat = 1'b1;
    end else begin
      mean_c = neg_r ? 32'd0 - quo[31:0] : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= tlg_pkg::KIND_MSE;
      grad_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        tlg_pkg::REG_LOSS_KIND: kind_r <= cfg_wdata;
        tlg_pkg::REG_WANT_GRAD: grad_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == tlg_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      ec_r        <= '0;
      rc_r        <= '0;
      clip_r      <= 1'b0;
      pos_r       <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      case (cmd.op)
        tlg_pkg::OP_CAPTURE: begin
          pos_r  <= pos_c;
          last_r <= in_tlast;
          if (ec_r < CW'(COUNT_CAP)) ec_r <= ec_r + 1'b1;
          if ((in_tuser || in_tlast) && rc_r < CW'(COUNT_CAP)) rc_r <= rc_r + 1'b1;
        end
        tlg_pkg::OP_ACC: begin
          if (acc_s[64] != acc_s[63]) begin
            clip_r <= 1'b1;
            sum_r  <= acc_s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          end else begin
            sum_r <= acc_s[63:0];
          end
        end
        tlg_pkg::OP_OUT: begin
          sum_r       <= '0;
          ec_r        <= '0;
          rc_r        <= '0;
          clip_r      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tlg_pkg::OP_CAPTURE: begin
        d_r     <= {in_pred[31], in_pred} - {in_truth[31], in_truth};
        truth_r <= in_truth;
        p_r     <= p_c;
        term_r  <= '0;
      end
      tlg_pkg::OP_MSE_GRAD: term_r <= {{(TW - 34){d_r[32]}}, d_r, 1'b0};
      tlg_pkg::OP_MSE_SQ:   term_r <= TW'(sq_rnd[64:16]);
      tlg_pkg::OP_LOG_INIT: begin
        e_r    <= le;
        m_r    <= m_init;
        frac_r <= '0;
      end
      tlg_pkg::OP_LOG_STEP: begin
        m_r    <= lt[31] ? lt[31:1] : lt[30:0];
        frac_r <= {frac_r[30:0], lt[31]};
      end
      tlg_pkg::OP_LOG_MUL: lprod_r <= 63'(ldist[36:4]) * 63'(tlg_pkg::LN2_Q30);
      tlg_pkg::OP_LOG_END: begin
        if (cmd.sel) begin
          nlq_r <= lrnd[62:42];
        end else begin
          nlp_r  <= lrnd[62:42];
          term_r <= TW'(lrnd[62:42]);
        end
      end
      tlg_pkg::OP_BCE_MUL: begin
        if (cmd.sel) mq_r <= mq_c;
        else mt_r <= mt_c;
      end
      tlg_pkg::OP_BCE_SUM:
        term_r <= bce_v[55] ? TW'(0) - TW'(bce_rnd) : TW'(bce_rnd);
      tlg_pkg::OP_DIV_START: neg_r <= neg_c;
      tlg_pkg::OP_TERM_ADD: term_r <= term_r + qterm;
      tlg_pkg::OP_TERM_SUB: term_r <= term_r - qterm;
      tlg_pkg::OP_OUT: begin
        out_data_r <= mean_c;
        out_sat_r  <= clip_r | mean_sat;
      end
      default: ;
    endcase
  end

  assign stat.kind     = kind_r;
  assign stat.grad     = grad_r;
  assign stat.positive = pos_r;
  assign stat.last     = last_r;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

@@ src/tlg_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine that sequences the datapath operations per transaction.
// Uses tlg_pkg for command and status types and codes.
module tlg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tlg_pkg::tlg_stat_t stat,
  output tlg_pkg::tlg_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_LOGI2 = 4'd2;
  localparam logic [3:0] S_LOG   = 4'd3;
  localparam logic [3:0] S_LOGM  = 4'd4;
  localparam logic [3:0] S_LOGE  = 4'd5;
  localparam logic [3:0] S_BM0   = 4'd6;
  localparam logic [3:0] S_BM1   = 4'd7;
  localparam logic [3:0] S_BSUM  = 4'd8;
  localparam logic [3:0] S_DIVS2 = 4'd9;
  localparam logic [3:0] S_DIVW  = 4'd10;
  localparam logic [3:0] S_ACC   = 4'd11;
  localparam logic [3:0] S_MEANS = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       lsel_r, lsel_nxt;
  logic [1:0] dsel_r, dsel_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    lsel_nxt  = lsel_r;
    dsel_nxt  = dsel_r;
    cmd.op    = tlg_pkg::OP_NONE;
    cmd.sel   = lsel_r;
    cmd.dsel  = dsel_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = tlg_pkg::OP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        lsel_nxt = 1'b0;
        step_nxt = '0;
        cmd.sel  = 1'b0;
        case (stat.kind)
          tlg_pkg::KIND_MSE: begin
            cmd.op    = stat.grad ? tlg_pkg::OP_MSE_GRAD : tlg_pkg::OP_MSE_SQ;
            state_nxt = S_ACC;
          end
          tlg_pkg::KIND_BCE: begin
            if (stat.grad) begin
              cmd.op    = tlg_pkg::OP_DIV_START;
              cmd.dsel  = tlg_pkg::DSEL_TCQ;
              dsel_nxt  = tlg_pkg::DSEL_TCQ;
              state_nxt = S_DIVW;
            end else begin
              cmd.op    = tlg_pkg::OP_LOG_INIT;
              state_nxt = S_LOG;
            end
          end
          default: begin
            if (!stat.positive) begin
              state_nxt = S_ACC;
            end else if (stat.grad) begin
              cmd.op    = tlg_pkg::OP_DIV_START;
              cmd.dsel  = tlg_pkg::DSEL_ONEP;
              dsel_nxt  = tlg_pkg::DSEL_ONEP;
              state_nxt = S_DIVW;
            end else begin
              cmd.op    = tlg_pkg::OP_LOG_INIT;
              state_nxt = S_LOG;
            end
          end
        endcase
      end
      S_LOGI2: begin
        cmd.op    = tlg_pkg::OP_LOG_INIT;
        cmd.sel   = 1'b1;
        lsel_nxt  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.op   = tlg_pkg::OP_LOG_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd31) state_nxt = S_LOGM;
      end
      S_LOGM: begin
        cmd.op    = tlg_pkg::OP_LOG_MUL;
        state_nxt = S_LOGE;
      end
      S_LOGE: begin
        cmd.op = tlg_pkg::OP_LOG_END;
        if (stat.kind == tlg_pkg::KIND_BCE) begin
          state_nxt = lsel_r ? S_BM0 : S_LOGI2;
        end else begin
          state_nxt = S_ACC;
        end
      end
      S_BM0: begin
        cmd.op    = tlg_pkg::OP_BCE_MUL;
        cmd.sel   = 1'b0;
        state_nxt = S_BM1;
      end
      S_BM1: begin
        cmd.op    = tlg_pkg::OP_BCE_MUL;
        cmd.sel   = 1'b1;
        state_nxt = S_BSUM;
      end
      S_BSUM: begin
        cmd.op    = tlg_pkg::OP_BCE_SUM;
        state_nxt = S_ACC;
      end
      S_DIVS2: begin
        cmd.op    = tlg_pkg::OP_DIV_START;
        cmd.dsel  = tlg_pkg::DSEL_TP;
        dsel_nxt  = tlg_pkg::DSEL_TP;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          case (dsel_r)
            tlg_pkg::DSEL_TCQ: begin
              cmd.op    = tlg_pkg::OP_TERM_ADD;
              state_nxt = S_DIVS2;
            end
            tlg_pkg::DSEL_MEAN: state_nxt = S_OUT;
            default: begin
              cmd.op    = tlg_pkg::OP_TERM_SUB;
              state_nxt = S_ACC;
            end
          endcase
        end
      end
      S_ACC: begin
        cmd.op    = tlg_pkg::OP_ACC;
        state_nxt = stat.last ? S_MEANS : S_IDLE;
      end
      S_MEANS: begin
        cmd.op    = tlg_pkg::OP_DIV_START;
        cmd.dsel  = tlg_pkg::DSEL_MEAN;
        dsel_nxt  = tlg_pkg::DSEL_MEAN;
        state_nxt = S_DIVW;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = tlg_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      lsel_r  <= 1'b0;
      dsel_r  <= tlg_pkg::DSEL_TCQ;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      lsel_r  <= lsel_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

endmodule

@@ src/training_loss_and_gradient_engine.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | tdata (lowest bit up)                          | tuser     | tlast
// in_      | slave     | pred_value, truth_value, class_index,          | row_end   | last
//          |           | label_index, 4 zero bits                       |           |
// out_     | master    | mean_result                                    | saturated | -
// cfg_     | write     | cfg_addr 0 loss_kind, 1 want_gradient          | -         | -
//
// One transaction at a time. A logarithm takes setup, 32 squaring steps, a multiply and a
// round; gradients use divisions in the shared divider. Mean squared error and a non-positive
// categorical element use neither; binary cross entropy takes a logarithm of p and of 1-p
// for its loss and a division per term for its gradient, categorical one of either.
// A last transaction adds the mean division and the result load.
// Reset is synchronous, active low. The result register lets a new transaction
// in while the previous result waits; a waiting result stalls only the load of the next mean.
module training_loss_and_gradient_engine #(
  parameter int MAX_ELEMENTS = tlg_pkg::DEF_MAX_ELEMENTS,
  parameter int NUM_CLASSES  = tlg_pkg::DEF_NUM_CLASSES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pred_value, truth_value, class_index, label_index, zero fill
  input  logic [tlg_pkg::IN_TDATA_W-1:0] in_tdata,
  // row_end
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // mean_result
  output logic [31:0]                    out_tdata,
  // saturated
  output logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [1:0]                     cfg_wdata
);

  tlg_pkg::tlg_cmd_t  cmd;
  tlg_pkg::tlg_stat_t stat;

  tlg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlg_dp #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

@@ src/tlg_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the training loss and gradient engine, bound to the top level.
// Uses tlg_pkg for port widths.
module tlg_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [tlg_pkg::IN_TDATA_W-1:0] in_tdata,
  input logic                           in_tuser,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [31:0]                    out_tdata,
  input logic                           out_tuser,
  input logic                           cfg_we,
  input logic                           cfg_addr,
  input logic [1:0]                     cfg_wdata
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("Block not idle after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted while a transaction is in progress.");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("Result appeared without a transaction in progress.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result changed.");

endmodule

bind training_loss_and_gradient_engine tlg_checker u_tlg_checker (.*);
